FILE: hdl/assert_macros.svh
// Assertion macros used by the allocator core RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

FILE: hdl/rpa_pkg.sv
// Package for the refcounted page allocator: widths, codes and bus structs.
// No dependencies.
`default_nettype none

package rpa_pkg;

    localparam int PAGE_W         = 36;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int PCOUNT_W       = 13;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 36;
    localparam int MAX_PAGES_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_REUSE = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_SAT     = 2'd3
    } status_t;

    typedef struct packed {
        logic rd_en;
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/refcounted_page_allocator_core.sv
// Top level of the refcounted page allocator: region registers, request
// stage, update/write-back and result register. Depends on rpa_pkg,
// rpa_count_ram, rpa_recycle_q and assert_macros.svh.

// In the accept cycle the count memory and the recycle queue head are read
// (registered reads). The request then executes, held while a waiting
// result is stalled at the output: the count is updated and written back
// and the result is loaded into the output register. A new request is
// taken in the cycle after that, and a stalled waiting result holds off
// the next request. No clearing pass runs after reset: counts of offsets
// at or beyond the fresh-allocation pointer read as zero.
`default_nettype none

`include "assert_macros.svh"

module refcounted_page_allocator_core #(
    parameter int MAX_PAGES  = rpa_pkg::MAX_PAGES_DEF,
    parameter int COUNT_BITS = rpa_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [rpa_pkg::CMD_W-1:0]       command,
    input  logic [rpa_pkg::PAGE_W-1:0]      page_number,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [rpa_pkg::PAGE_W-1:0]      granted_page,
    output logic [rpa_pkg::STATUS_W-1:0]    status,
    output logic                            released,
    output logic                            shared,
    input  logic                            cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import rpa_pkg::*;

    localparam int OFF_W  = $clog2(MAX_PAGES);
    localparam int FILL_W = $clog2(MAX_PAGES + 1);
    localparam int SZ_W   = (FILL_W > PCOUNT_W) ? FILL_W : PCOUNT_W;
    localparam logic [SZ_W-1:0]       MAX_SZ    = SZ_W'(MAX_PAGES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // region registers
    logic [PAGE_W-1:0]   base_reg;
    logic [PCOUNT_W-1:0] pcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            pcount_reg <= PCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:  base_reg   <= cfg_data[PAGE_W-1:0];
                REG_COUNT: pcount_reg <= cfg_data[PCOUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    logic [SZ_W-1:0]   pcount_ext, size;
    logic [PAGE_W-1:0] diff;
    logic              in_region, accept;

    assign pcount_ext = SZ_W'(pcount_reg);
    assign size       = (pcount_ext < MAX_SZ) ? pcount_ext : MAX_SZ;
    assign diff       = page_number - base_reg;
    assign in_region  = diff < PAGE_W'(size);

    // request stage
    logic             s1_valid_reg;
    cmd_t             cmd_reg;
    logic [OFF_W-1:0] off_reg;
    logic             inreg_reg;
    logic             exec_fire;
    logic             out_valid_reg;

    assign in_stall  = s1_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign exec_fire = s1_valid_reg && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd_t'(command);
            off_reg   <= diff[OFF_W-1:0];
            inreg_reg <= in_region;
        end
    end

    // memories
    logic [COUNT_BITS-1:0] cnt_rd;
    logic                  cnt_we;
    logic [OFF_W-1:0]      cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    q_ctl_t                q_ctl;
    q_stat_t               q_stat;
    logic [OFF_W-1:0]      q_head_off;

    rpa_count_ram #(
        .DEPTH  (MAX_PAGES),
        .ADDR_W (OFF_W),
        .DATA_W (COUNT_BITS)
    ) u_count_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (diff[OFF_W-1:0]),
        .rd_data (cnt_rd),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata)
    );

    rpa_recycle_q #(
        .DEPTH (MAX_PAGES),
        .OFF_W (OFF_W)
    ) u_recycle_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (q_ctl),
        .push_off (off_reg),
        .head_off (q_head_off),
        .stat     (q_stat)
    );

    // update and write-back
    logic [FILL_W-1:0]     fresh_reg, fresh_next;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  fresh_avail;
    logic [OFF_W-1:0]      alloc_off;
    logic [PAGE_W-1:0]     res_granted;
    status_t               res_status;
    logic                  res_released, res_shared;

    assign cur_cnt     = (FILL_W'(off_reg) < fresh_reg) ? cnt_rd : '0;
    assign fresh_avail = SZ_W'(fresh_reg) < size;

    always_comb
    begin
        fresh_next   = fresh_reg;
        cnt_we       = 1'b0;
        cnt_waddr    = off_reg;
        cnt_wdata    = '0;
        q_ctl.rd_en  = accept;
        q_ctl.push   = 1'b0;
        q_ctl.pop    = 1'b0;
        alloc_off    = '0;
        res_granted  = '0;
        res_status   = ST_OK;
        res_released = 1'b0;
        res_shared   = 1'b0;
        if (exec_fire)
        begin
            unique case (cmd_reg)
                CMD_ALLOC:
                begin
                    priority if (fresh_avail)
                    begin
                        alloc_off   = fresh_reg[OFF_W-1:0];
                        fresh_next  = fresh_reg + FILL_W'(1);
                        cnt_we      = 1'b1;
                        cnt_waddr   = alloc_off;
                        cnt_wdata   = COUNT_ONE;
                        res_granted = base_reg + PAGE_W'(alloc_off);
                    end
                    else if (!q_stat.empty)
                    begin
                        alloc_off   = q_head_off;
                        q_ctl.pop   = 1'b1;
                        cnt_we      = 1'b1;
                        cnt_waddr   = alloc_off;
                        cnt_wdata   = COUNT_ONE;
                        res_granted = base_reg + PAGE_W'(alloc_off);
                    end
                    else
                    begin
                        res_status = ST_EMPTY;
                    end
                end
                CMD_REUSE:
                begin
                    priority if (!inreg_reg || cur_cnt == '0)
                    begin
                        res_status = ST_UNKNOWN;
                    end
                    else if (cur_cnt == COUNT_MAX)
                    begin
                        res_status = ST_SAT;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cur_cnt + COUNT_ONE;
                    end
                end
                CMD_FREE:
                begin
                    priority if (!inreg_reg || cur_cnt == '0)
                    begin
                        res_status = ST_UNKNOWN;
                    end
                    else if (cur_cnt == COUNT_ONE)
                    begin
                        cnt_we       = 1'b1;
                        cnt_wdata    = '0;
                        res_released = 1'b1;
                        q_ctl.push   = 1'b1;
                    end
                    else
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = cur_cnt - COUNT_ONE;
                    end
                end
                CMD_QUERY:
                begin
                    res_shared = inreg_reg && (cur_cnt > COUNT_ONE);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    logic [PAGE_W-1:0]   granted_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                released_reg, shared_reg;

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            granted_reg  <= res_granted;
            status_reg   <= res_status;
            released_reg <= res_released;
            shared_reg   <= res_shared;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_page = granted_reg;
    assign status       = status_reg;
    assign released     = released_reg;
    assign shared       = shared_reg;

    `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, exec_fire, out_valid_reg)
    `ASSERT_IMPLIES(a_fresh_bound, clk, rst_n, 1'b1, fresh_reg <= FILL_W'(MAX_PAGES))
    `ASSERT_IMPLIES(a_push_not_full, clk, rst_n, q_ctl.push, !q_stat.full)
    `ASSERT_IMPLIES(a_release_ok, clk, rst_n, out_valid_reg && released_reg, status_reg == ST_OK)

endmodule

`default_nettype wire

FILE: hdl/rpa_count_ram.sv
// Reference count memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module rpa_count_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/rpa_recycle_q.sv
// Recycle queue of freed page offsets: ring memory with head, tail and fill.
// Depends on rpa_pkg.
`default_nettype none

module rpa_recycle_q #(
    parameter int DEPTH = 4096,
    parameter int OFF_W = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rpa_pkg::q_ctl_t  ctl,
    input  logic [OFF_W-1:0] push_off,
    output logic [OFF_W-1:0] head_off,
    output rpa_pkg::q_stat_t stat
);

    import rpa_pkg::*;

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [OFF_W-1:0]  LAST = OFF_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL = FILL_W'(DEPTH);

    logic [OFF_W-1:0]  mem [DEPTH];
    logic [OFF_W-1:0]  head_reg, head_next;
    logic [OFF_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FULL);
    assign do_push    = ctl.push && !stat.full;
    assign do_pop     = ctl.pop && !stat.empty;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            tail_next = (tail_reg == LAST) ? '0 : tail_reg + OFF_W'(1);
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (do_pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + OFF_W'(1);
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail_reg] <= push_off;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            head_off <= mem[head_reg];
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_refcounted_page_allocator_core.sv
// Self-checking bench for refcounted_page_allocator_core: alloc, reuse, free and query
// requests checked against an in-bench allocator predictor across several region settings.
// Depends on rpa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_refcounted_page_allocator_core;

    import rpa_pkg::*;

    localparam int MAX_PAGES  = MAX_PAGES_DEF;
    localparam int COUNT_BITS = COUNT_BITS_DEF;
    localparam int OFF_W      = $clog2(MAX_PAGES);
    localparam int LONG_HOLD  = 150;

    typedef struct {
        cmd_t              cmd;
        logic [PAGE_W-1:0] page;
    } page_req_t;

    typedef struct {
        logic [PAGE_W-1:0] granted;
        status_t           status;
        logic              released;
        logic              shared;
    } page_outcome_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [CMD_W-1:0]      command     = CMD_ALLOC;
    logic [PAGE_W-1:0]     page_number = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [PAGE_W-1:0]     granted_page;
    logic [STATUS_W-1:0]   status;
    logic                  released;
    logic                  shared;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = REG_BASE;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    // predictor state
    logic [PAGE_W-1:0]     base_cfg   = '0;
    logic [PCOUNT_W-1:0]   count_cfg  = PCOUNT_RESET;
    logic [PCOUNT_W-1:0]   fresh_next = '0;
    logic [OFF_W-1:0]      recycled_offs[$];
    logic [COUNT_BITS-1:0] ref_cnt[MAX_PAGES] = '{default: '0};
    logic [PAGE_W-1:0]     last_granted = '0;

    page_req_t     reqs_pending[$];
    page_outcome_t outcomes_due[$];

    bit no_idle          = 1'b0;
    int gap_left         = 0;
    int hold_left        = 0;
    int long_holds_asked = 0;
    int long_holds_done  = 0;
    int fail_count       = 0;
    int n_results        = 0;
    int n_status[4]      = '{default: 0};
    int n_released       = 0;
    int n_shared         = 0;

    refcounted_page_allocator_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .page_number  (page_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_page (granted_page),
        .status       (status),
        .released     (released),
        .shared       (shared),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int unsigned region_span();
        return (count_cfg < MAX_PAGES) ? count_cfg : MAX_PAGES;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic page_outcome_t apply_page_command(cmd_t cmd, logic [PAGE_W-1:0] page);
        page_outcome_t     r;
        logic [PAGE_W-1:0] off_full;
        logic [OFF_W-1:0]  off;
        bit                in_region;
        r.granted  = '0;
        r.status   = ST_OK;
        r.released = 1'b0;
        r.shared   = 1'b0;
        off_full   = page - base_cfg;
        in_region  = off_full < region_span();
        off        = off_full[OFF_W-1:0];
        case (cmd)
            CMD_ALLOC:
            begin
                if (fresh_next < region_span())
                begin
                    off = fresh_next[OFF_W-1:0];
                    fresh_next++;
                    ref_cnt[off] = 1;
                    r.granted = base_cfg + off;
                end
                else if (recycled_offs.size() != 0)
                begin
                    off = recycled_offs[0];
                    recycled_offs.delete(0);
                    ref_cnt[off] = 1;
                    r.granted = base_cfg + off;
                end
                else
                    r.status = ST_EMPTY;
                if (r.status == ST_OK)
                    last_granted = r.granted;
            end
            CMD_REUSE:
            begin
                if (!in_region || ref_cnt[off] == 0)
                    r.status = ST_UNKNOWN;
                else if (ref_cnt[off] == {COUNT_BITS{1'b1}})
                    r.status = ST_SAT;
                else
                    ref_cnt[off]++;
            end
            CMD_FREE:
            begin
                if (!in_region || ref_cnt[off] == 0)
                    r.status = ST_UNKNOWN;
                else if (ref_cnt[off] == 1)
                begin
                    ref_cnt[off] = 0;
                    r.released = 1'b1;
                    recycled_offs.insert(recycled_offs.size(), off);
                end
                else
                    ref_cnt[off]--;
            end
            default:
                r.shared = in_region && ref_cnt[off] > 1;
        endcase
        return r;
    endfunction

    task automatic check_field(string what, logic [PAGE_W-1:0] want, logic [PAGE_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        int        g;
        bit        busy;
        page_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            g    = gap_left;
            busy = in_valid;
            if (in_valid && !in_stall)
            begin
                outcomes_due.insert(outcomes_due.size(),
                                    apply_page_command(cmd_t'(command), page_number));
                busy = 1'b0;
                g    = draw_wait();
            end
            if (!busy)
            begin
                if (g > 0)
                begin
                    in_valid <= 1'b0;
                    g--;
                end
                else if (reqs_pending.size() != 0)
                begin
                    req = reqs_pending[0];
                    reqs_pending.delete(0);
                    in_valid    <= 1'b1;
                    command     <= req.cmd;
                    page_number <= req.page;
                end
                else
                    in_valid <= 1'b0;
            end
            gap_left <= g;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int            w;
        page_outcome_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            w = hold_left;
            if (out_valid && !out_stall)
            begin
                w = draw_wait();
                n_results++;
                n_status[status]++;
                n_released += released;
                n_shared   += shared;
                if (outcomes_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no request outstanding, status %0d, page %h",
                             $time, status, granted_page);
                end
                else
                begin
                    want = outcomes_due[0];
                    outcomes_due.delete(0);
                    check_field("granted_page", want.granted, granted_page);
                    check_field("status", want.status, status);
                    check_field("released", want.released, released);
                    check_field("shared", want.shared, shared);
                end
            end
            if (long_holds_done != long_holds_asked)
            begin
                w = LONG_HOLD;
                long_holds_done++;
            end
            out_stall <= (w > 0);
            hold_left <= (w > 0) ? w - 1 : 0;
        end
    end

    task automatic queue_req(cmd_t cmd, logic [PAGE_W-1:0] page);
        page_req_t req;
        while (reqs_pending.size() >= 4)
            @(posedge clk);
        req.cmd  = cmd;
        req.page = page;
        reqs_pending.insert(reqs_pending.size(), req);
    endtask

    task automatic wait_drained();
        while (reqs_pending.size() != 0 || in_valid || outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == REG_BASE)
            base_cfg = value[PAGE_W-1:0];
        else
            count_cfg = value[PCOUNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        int unsigned  used;
        logic [63:0]  rnd;
        used = (fresh_next < region_span()) ? fresh_next : region_span();
        rnd  = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                return (used == 0) ? base_cfg : base_cfg + $urandom_range(0, used - 1);
            6:       return base_cfg + $urandom_range(0, region_span());
            7:       return base_cfg - 1;
            8:       return rnd[PAGE_W-1:0];
            default: return $urandom_range(0, 1) ? '0 : '1;
        endcase
    endfunction

    function automatic cmd_t pick_cmd();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CMD_ALLOC;
        else if (r < 55)
            return CMD_REUSE;
        else if (r < 85)
            return CMD_FREE;
        return CMD_QUERY;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            queue_req(pick_cmd(), pick_page());
    endtask

    initial
    begin : stimulus
        logic [PAGE_W-1:0] sat_page;
        logic [63:0]       rnd;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        no_idle = 1'b1;
        write_reg(REG_BASE, '0);
        write_reg(REG_COUNT, PCOUNT_RESET);

        // basic lifecycle, unknown pages, back-to-back on one page
        queue_req(CMD_ALLOC, '1);
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_QUERY, 36'd0);
        queue_req(CMD_REUSE, 36'd0);
        queue_req(CMD_QUERY, 36'd0);
        queue_req(CMD_FREE, 36'd0);
        queue_req(CMD_FREE, 36'd0);
        queue_req(CMD_FREE, 36'd0);
        queue_req(CMD_QUERY, 36'd0);
        queue_req(CMD_REUSE, 36'd0);
        queue_req(CMD_REUSE, 36'd4095);
        queue_req(CMD_FREE, 36'd4096);
        queue_req(CMD_QUERY, '1);
        queue_req(CMD_REUSE, '1);
        queue_req(CMD_FREE, 36'd1);
        queue_req(CMD_ALLOC, '0);
        queue_req(CMD_REUSE, 36'd2);
        queue_req(CMD_REUSE, 36'd2);
        queue_req(CMD_QUERY, 36'd2);
        queue_req(CMD_FREE, 36'd2);
        wait_drained();

        // raise one page's count a few times back to back
        sat_page = last_granted;
        for (int i = 0; i < 6; i++)
            queue_req(CMD_REUSE, sat_page);
        queue_req(CMD_QUERY, sat_page);
        queue_req(CMD_FREE, sat_page);
        wait_drained();
        no_idle = 1'b0;

        // tiny region near the top of the page space
        write_reg(REG_BASE, 36'hFFFFFFFF0);
        write_reg(REG_COUNT, 13'd3);
        run_random(100);
        wait_drained();

        write_reg(REG_COUNT, '0);
        run_random(40);
        wait_drained();

        write_reg(REG_BASE, '1);
        write_reg(REG_COUNT, 13'd64);
        run_random(120);
        wait_drained();

        rnd = {$urandom(), $urandom()};
        write_reg(REG_BASE, rnd[PAGE_W-1:0]);
        write_reg(REG_COUNT, '1);
        run_random(80);
        long_holds_asked++;
        run_random(80);
        no_idle = 1'b1;
        run_random(80);
        no_idle = 1'b0;
        wait_drained();

        write_reg(REG_BASE, '0);
        write_reg(REG_COUNT, PCOUNT_RESET);
        run_random(120);
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Checked %0d results: %0d ok, %0d no free page, %0d unknown page, %0d saturated",
                 n_results, n_status[ST_OK], n_status[ST_EMPTY], n_status[ST_UNKNOWN],
                 n_status[ST_SAT]);
        $display("%0d pages released, %0d shared queries, %0d requests left outstanding",
                 n_released, n_shared, outcomes_due.size());
        if (fail_count == 0 && outcomes_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", outcomes_due.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/rpa_pkg.sv
hdl/rpa_count_ram.sv
hdl/rpa_recycle_q.sv
hdl/refcounted_page_allocator_core.sv
bench/tb_refcounted_page_allocator_core.sv
